// ----- design/bms_pkg.sv -----
package bms_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  localparam int CH_W      = 8;
  localparam int SCORE_W   = 16;
  localparam int TOTAL_W   = 48;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = SCORE_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_ROUND  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_SQUARE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_CURLY  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_ANGLE  = 4'd3;

  localparam logic [SCORE_W-1:0] RST_SCORE_ROUND  = 16'd3;
  localparam logic [SCORE_W-1:0] RST_SCORE_SQUARE = 16'd57;
  localparam logic [SCORE_W-1:0] RST_SCORE_CURLY  = 16'd1197;
  localparam logic [SCORE_W-1:0] RST_SCORE_ANGLE  = 16'd25137;

  localparam logic [CH_W-1:0] CH_OPEN_ROUND   = 8'h28;
  localparam logic [CH_W-1:0] CH_CLOSE_ROUND  = 8'h29;
  localparam logic [CH_W-1:0] CH_OPEN_SQUARE  = 8'h5b;
  localparam logic [CH_W-1:0] CH_CLOSE_SQUARE = 8'h5d;
  localparam logic [CH_W-1:0] CH_OPEN_CURLY   = 8'h7b;
  localparam logic [CH_W-1:0] CH_CLOSE_CURLY  = 8'h7d;
  localparam logic [CH_W-1:0] CH_OPEN_ANGLE   = 8'h3c;
  localparam logic [CH_W-1:0] CH_CLOSE_ANGLE  = 8'h3e;

  typedef enum logic [1:0] {
    KIND_ROUND,
    KIND_SQUARE,
    KIND_CURLY,
    KIND_ANGLE
  } kind_t;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_t kind;
  } char_class_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    logic  clear;
    kind_t kind;
  } stack_op_t;

  typedef struct packed {
    kind_t            top;
    logic             empty;
    logic             full;
    logic [CNT_W-1:0] count;
  } stack_stat_t;

  typedef struct packed {
    logic corrupt;
    logic bad_char;
    logic overflow;
  } line_flags_t;

  typedef struct packed {
    logic [SCORE_W-1:0] line_score;
    line_flags_t        flags;
    logic [TOTAL_W-1:0] total_score;
  } result_t;

  function automatic char_class_t classify(logic [CH_W-1:0] c);
    char_class_t r;
    r = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    unique case (c)
      CH_OPEN_ROUND:   r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ROUND};
      CH_OPEN_SQUARE:  r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
      CH_OPEN_CURLY:   r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
      CH_OPEN_ANGLE:   r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
      CH_CLOSE_ROUND:  r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ROUND};
      CH_CLOSE_SQUARE: r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
      CH_CLOSE_CURLY:  r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
      CH_CLOSE_ANGLE:  r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
      default:         r = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    endcase
    return r;
  endfunction

endpackage

// ----- design/bms_if.sv -----
interface bms_char_if import bms_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            line_end;

  modport source (output valid, output ch, output line_end, input ready);
  modport sink (input valid, input ch, input line_end, output ready);
endinterface

interface bms_result_if import bms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] line_score;
  logic               corrupt;
  logic               bad_char;
  logic               overflow;
  logic [TOTAL_W-1:0] total_score;

  modport source (output valid, output line_score, output corrupt, output bad_char,
                  output overflow, output total_score, input ready);
  modport sink (input valid, input line_score, input corrupt, input bad_char,
                input overflow, input total_score, output ready);
endinterface

// ----- design/bms_stack.sv -----
module bms_stack import bms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  stack_op_t   op,
  output stack_stat_t stat
);

  // top of stack lives in a register, entries below it in the memory
  kind_t            mem [STACK_DEPTH];
  kind_t            top;
  kind_t            top_next;
  kind_t            below;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_m2;
  logic             full;
  logic             empty;
  logic             do_push;
  logic             do_pop;
  logic             we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;

  assign full    = (count == CNT_W'(STACK_DEPTH));
  assign empty   = (count == '0);
  assign do_push = op.push && !full;
  assign do_pop  = op.pop && !empty;

  always_comb begin
    if (op.clear) begin
      count_next = '0;
    end else if (do_push) begin
      count_next = count + CNT_W'(1);
    end else if (do_pop) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  always_comb begin
    if (do_push) begin
      top_next = op.kind;
    end else if (do_pop) begin
      top_next = below;
    end else begin
      top_next = top;
    end
  end

  // old top spills to the memory on a push; the entry under the new top is
  // prefetched every cycle at the next count minus two
  assign cnt_m1 = count - CNT_W'(1);
  assign cnt_m2 = count_next - CNT_W'(2);
  assign we     = do_push && !empty;
  assign waddr  = cnt_m1[ADDR_W-1:0];
  assign raddr  = cnt_m2[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= top;
    end
  end

  // a push always reads back the entry it writes, so forward it
  always_ff @(posedge clk) begin
    if (we) begin
      below <= top;
    end else begin
      below <= mem[raddr];
    end
    top <= top_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign stat = '{top: top, empty: empty, full: full, count: count};

endmodule

// ----- design/bracket_match_error_scorer.sv -----
// Bracket checker: one char byte is taken per cycle on chars when ready, with
// line_end marking the last byte of a line. Openers ( [ { < are pushed on a
// stack of STACK_DEPTH entries; a matching closer pops it. The first wrong or
// unopened closer marks the line corrupt with that closer's score register;
// a non-delimiter byte or a push onto a full stack flags bad_char or overflow
// with score 0. After any of these the rest of the line is skipped. Each
// line end gives one result on results with a saturating 48-bit total. Items
// follow back to back while chars.ready is high: the stack top is held
// in a register and the entry beneath it is prefetched from the one stack
// memory each cycle, with the spilled entry forwarded on a push. Results
// sit in a two-entry queue, and chars.ready drops only while both entries
// wait. The stack memory needs no clearing after reset. Score registers are
// written through cfg_we, cfg_index and cfg_data; other indexes are ignored.
module bracket_match_error_scorer import bms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  bms_char_if.sink             chars,
  bms_result_if.source         results,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [SCORE_W-1:0] score_reg [4];

  logic               done;
  logic               done_next;
  logic [SCORE_W-1:0] lscore;
  logic [SCORE_W-1:0] lscore_next;
  line_flags_t        flags;
  line_flags_t        flags_next;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;
  logic [TOTAL_W:0]   sum;

  char_class_t        cc;
  stack_op_t          op;
  stack_stat_t        stat;
  logic               accept;
  logic               emit;
  result_t            new_res;

  result_t            q0;
  result_t            q1;
  logic [1:0]         q_cnt;
  logic               q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_reg[KIND_ROUND]  <= RST_SCORE_ROUND;
      score_reg[KIND_SQUARE] <= RST_SCORE_SQUARE;
      score_reg[KIND_CURLY]  <= RST_SCORE_CURLY;
      score_reg[KIND_ANGLE]  <= RST_SCORE_ANGLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCORE_ROUND:  score_reg[KIND_ROUND]  <= cfg_data[SCORE_W-1:0];
        CFG_SCORE_SQUARE: score_reg[KIND_SQUARE] <= cfg_data[SCORE_W-1:0];
        CFG_SCORE_CURLY:  score_reg[KIND_CURLY]  <= cfg_data[SCORE_W-1:0];
        CFG_SCORE_ANGLE:  score_reg[KIND_ANGLE]  <= cfg_data[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = chars.valid && chars.ready;
  assign emit   = accept && chars.line_end;
  assign cc     = classify(chars.ch);

  always_comb begin
    op          = '{push: 1'b0, pop: 1'b0, clear: emit, kind: cc.kind};
    done_next   = done;
    lscore_next = lscore;
    flags_next  = flags;
    if (accept && !done) begin
      if (cc.is_open) begin
        if (stat.full) begin
          flags_next.overflow = 1'b1;
          done_next           = 1'b1;
        end else begin
          op.push = 1'b1;
        end
      end else if (cc.is_close) begin
        if (stat.empty || (stat.top != cc.kind)) begin
          flags_next.corrupt = 1'b1;
          lscore_next        = score_reg[cc.kind];
          done_next          = 1'b1;
        end else begin
          op.pop = 1'b1;
        end
      end else begin
        flags_next.bad_char = 1'b1;
        done_next           = 1'b1;
      end
    end
  end

  // carry out of the add means the total saturates
  assign sum = {1'b0, total} + (TOTAL_W + 1)'(lscore_next);

  always_comb begin
    if (!emit) begin
      total_next = total;
    end else if (sum[TOTAL_W]) begin
      total_next = TOTAL_MAX;
    end else begin
      total_next = sum[TOTAL_W-1:0];
    end
  end

  assign new_res = '{line_score: lscore_next, flags: flags_next, total_score: total_next};

  bms_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      lscore <= '0;
      flags  <= '0;
      total  <= '0;
    end else begin
      total <= total_next;
      if (emit) begin
        done   <= 1'b0;
        lscore <= '0;
        flags  <= '0;
      end else begin
        done   <= done_next;
        lscore <= lscore_next;
        flags  <= flags_next;
      end
    end
  end

  // two-entry result queue
  assign q_pop       = results.valid && results.ready;
  assign chars.ready = (q_cnt != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else begin
      unique case ({emit, q_pop})
        2'b10:   q_cnt <= q_cnt + 2'd1;
        2'b01:   q_cnt <= q_cnt - 2'd1;
        default: q_cnt <= q_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_cnt == 2'd0) begin
      if (emit) begin
        q0 <= new_res;
      end
    end else if (q_cnt == 2'd1) begin
      if (emit && q_pop) begin
        q0 <= new_res;
      end else if (emit) begin
        q1 <= new_res;
      end
    end else begin
      if (q_pop) begin
        q0 <= q1;
      end
    end
  end

  assign results.valid       = (q_cnt != 2'd0);
  assign results.line_score  = q0.line_score;
  assign results.corrupt     = q0.flags.corrupt;
  assign results.bad_char    = q0.flags.bad_char;
  assign results.overflow    = q0.flags.overflow;
  assign results.total_score = q0.total_score;

`ifndef SYNTH
  a_emit_gives_result: assert property (@(posedge clk) disable iff (rst)
    emit |=> results.valid)
    else $error("line end item left no result");

  a_line_end_clears_stack: assert property (@(posedge clk) disable iff (rst)
    emit |=> (stat.count == '0))
    else $error("stack not cleared at line end");

  a_push_grows_stack: assert property (@(posedge clk) disable iff (rst)
    (op.push && !stat.full && !op.clear) |=> (stat.count == $past(stat.count) + 1))
    else $error("push did not grow the stack");

  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (total >= $past(total)))
    else $error("running total decreased");

  a_one_flag_per_line: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> ($countones({results.corrupt, results.bad_char,
                                   results.overflow}) <= 1))
    else $error("more than one line status flag set");
`endif

endmodule
